// ===== hw/rtl/aes_pkg.sv =====
// Shared types, constants and byte-, word- and state-level functions of the AES block cipher.
`default_nettype none

package aes_pkg;

    // Stage kinds of the round pipeline.
    localparam logic [1:0] RK_ADD  = 2'd0;
    localparam logic [1:0] RK_MID  = 2'd1;
    localparam logic [1:0] RK_FIN  = 2'd2;
    localparam logic [1:0] RK_PASS = 2'd3;

    // Configuration register indexes.
    localparam int         CFG_IW        = 3;
    localparam logic [2:0] IDX_KEY_SIZE  = 3'd0;
    localparam logic [2:0] IDX_KEY_WORD0 = 3'd1;
    localparam logic [2:0] IDX_KEY_WORD1 = 3'd2;
    localparam logic [2:0] IDX_KEY_WORD2 = 3'd3;
    localparam logic [2:0] IDX_KEY_WORD3 = 3'd4;

    // Key size codes.
    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;

    typedef struct packed {
        logic valid;
        logic op;
    } t_pipe_ctl;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24];
        a1 = c[23:16];
        a2 = c[15:8];
        a3 = c[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2, x4, x8;
        for (int i = 0; i < 4; i++) begin
            a[i]   = c[31-8*i -: 8];
            x2     = xt(a[i]);
            x4     = xt(x2);
            x8     = xt(x4);
            m9[i]  = x8 ^ a[i];
            m11[i] = x8 ^ x2 ^ a[i];
            m13[i] = x8 ^ x4 ^ a[i];
            m14[i] = x8 ^ x4 ^ x2;
        end
        return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
                m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
                m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            t[127-32*c -: 32] = mix_col(s[127-32*c -: 32]);
        return t;
    endfunction

    function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            t[127-32*c -: 32] = inv_mix_col(s[127-32*c -: 32]);
        return t;
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s);
        logic [127:0] t;
        for (int n = 0; n < 16; n++)
            t[127-8*n -: 8] = SBOX[s[127-8*n -: 8]];
        return t;
    endfunction

    function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
        logic [127:0] t;
        for (int n = 0; n < 16; n++)
            t[127-8*n -: 8] = INV_SBOX[s[127-8*n -: 8]];
        return t;
    endfunction

    // Byte r + 4c sits in row r, column c.
    function automatic logic [127:0] shift_rows(input logic [127:0] s);
        logic [127:0] t;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
        return t;
    endfunction

    function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
        logic [127:0] t;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aes_round.sv =====
// One registered stage of the cipher pipeline: add key, full round, last round or pass.
`default_nettype none

module aes_round
    import aes_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_pipe_ctl    i_ctl,
    output logic              o_ready,
    input  wire logic [127:0] i_state,
    input  wire logic [127:0] i_key_enc,
    input  wire logic [127:0] i_key_dec,
    input  wire logic [1:0]   i_kind,
    output t_pipe_ctl         o_ctl,
    input  wire logic         i_ready,
    output logic [127:0]      o_state
);

    t_pipe_ctl    r_ctl;
    logic [127:0] r_state;
    logic [127:0] n_state;
    logic [127:0] key;
    logic [127:0] sb;
    logic [127:0] sr;
    logic [127:0] mid;
    logic [127:0] fin;

    always_comb begin
        key = i_ctl.op ? i_key_dec : i_key_enc;
        if (!i_ctl.op) begin
            sb  = sub_bytes(i_state);
            sr  = shift_rows(sb);
            mid = mix_columns(sr);
            fin = sr;
        end else begin
            sr  = inv_shift_rows(i_state);
            sb  = inv_sub_bytes(sr);
            mid = inv_mix_columns(sb);
            fin = sb;
        end
        unique case (i_kind)
            RK_ADD:  n_state = i_state ^ key;
            RK_MID:  n_state = mid ^ key;
            RK_FIN:  n_state = fin ^ key;
            RK_PASS: n_state = i_state;
        endcase
    end

    // Advance when this stage is empty or its contents move on.
    assign o_ready = !r_ctl.valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            r_state <= n_state;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_state = r_state;

endmodule

`default_nettype wire

// ===== hw/rtl/aes_key_sched.sv =====
// Key registers and the word-serial round key expansion for both directions.
`default_nettype none

module aes_key_sched
    import aes_pkg::*;
#(
    parameter int MAX_ROUND_KEYS = 15
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic [CFG_IW-1:0]                 i_cfg_index,
    input  wire logic [63:0]                       i_cfg_data,
    output logic                                   o_busy,
    output logic [$clog2(MAX_ROUND_KEYS)-1:0]      o_rounds,
    output logic [127:0]                           o_enc_keys [MAX_ROUND_KEYS],
    output logic [127:0]                           o_dec_keys [MAX_ROUND_KEYS]
);

    localparam int RW = $clog2(MAX_ROUND_KEYS);
    localparam int IW = $clog2(4 * MAX_ROUND_KEYS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXP  = 2'd1;
    localparam logic [1:0] ST_DEC  = 2'd2;

    logic [1:0]    r_ks;
    logic [63:0]   r_kw [4];
    logic          r_start;
    logic [1:0]    r_state;
    logic [31:0]   r_win [8];
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_last;
    logic [2:0]    r_pos;
    logic [7:0]    r_rcon;
    logic [3:0]    r_nk;
    logic [RW-1:0] r_rounds;
    logic [RW-1:0] r_d;
    logic [127:0]  r_enc [MAX_ROUND_KEYS];
    logic [127:0]  r_dec [MAX_ROUND_KEYS];

    logic          cfg_wr;
    logic          do_load;
    logic          do_exp;
    logic          do_dec;
    logic [3:0]    ld_nk;
    logic [RW-1:0] ld_rounds;
    logic [31:0]   ld_win [8];
    logic [31:0]   tw;
    logic [31:0]   old_w;
    logic [31:0]   new_w;
    logic [RW-1:0] src;
    logic [127:0]  src_key;

    assign cfg_wr  = i_cfg_valid && (i_cfg_index <= IDX_KEY_WORD3);
    assign do_load = !cfg_wr && r_start;
    assign do_exp  = !cfg_wr && !r_start && (r_state == ST_EXP);
    assign do_dec  = !cfg_wr && !r_start && (r_state == ST_DEC);

    // Load values: key length in words and round count, capped by the storage.
    always_comb begin
        int nr;
        int j;
        unique case (r_ks)
            KS_192: begin
                ld_nk = 4'd6;
                nr    = 12;
            end
            KS_256: begin
                ld_nk = 4'd8;
                nr    = 14;
            end
            default: begin
                ld_nk = 4'd4;
                nr    = 10;
            end
        endcase
        if (nr > MAX_ROUND_KEYS - 1)
            nr = MAX_ROUND_KEYS - 1;
        ld_rounds = RW'(nr);
        for (int k = 0; k < 8; k++) begin
            j = int'(ld_nk) - 1 - k;
            if (j >= 0)
                ld_win[k] = (j % 2 == 0) ? r_kw[j/2][63:32] : r_kw[j/2][31:0];
            else
                ld_win[k] = '0;
        end
    end

    // Next expanded word; r_win[k] holds the word k + 1 places back.
    always_comb begin
        tw = r_win[0];
        if (r_pos == 3'd0)
            tw = sub_word({tw[23:0], tw[31:24]}) ^ {r_rcon, 24'h000000};
        else if (r_nk == 4'd8 && r_pos == 3'd4)
            tw = sub_word(tw);
        unique case (r_nk)
            4'd6:    old_w = r_win[5];
            4'd8:    old_w = r_win[7];
            default: old_w = r_win[3];
        endcase
        new_w = old_w ^ tw;
    end

    assign src     = r_rounds - r_d;
    assign src_key = r_enc[src];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks    <= KS_128;
            r_kw    <= '{default: '0};
            r_start <= 1'b1;
            r_state <= ST_IDLE;
        end else if (cfg_wr) begin
            if (i_cfg_index == IDX_KEY_SIZE)
                r_ks <= i_cfg_data[1:0];
            else
                r_kw[2'(i_cfg_index - IDX_KEY_WORD0)] <= i_cfg_data;
            r_start <= 1'b1;
        end else if (r_start) begin
            r_start <= 1'b0;
            r_state <= ST_EXP;
        end else begin
            unique case (r_state)
                ST_EXP:  if (r_idx == r_last) r_state <= ST_DEC;
                ST_DEC:  if (r_d == r_rounds) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_nk     <= ld_nk;
            r_rounds <= ld_rounds;
            r_last   <= IW'({ld_rounds, 2'b11});
            r_idx    <= IW'(ld_nk);
            r_pos    <= 3'd0;
            r_rcon   <= 8'h01;
            r_win    <= ld_win;
            r_enc[0] <= {r_kw[0], r_kw[1]};
            if (ld_nk != 4'd4)
                r_enc[1][127:64] <= r_kw[2];
            if (ld_nk == 4'd8)
                r_enc[1][63:0] <= r_kw[3];
        end
        if (do_exp) begin
            r_enc[r_idx[IW-1:2]][127-32*r_idx[1:0] -: 32] <= new_w;
            for (int k = 1; k < 8; k++)
                r_win[k] <= r_win[k-1];
            r_win[0] <= new_w;
            r_idx    <= r_idx + 1'b1;
            r_pos    <= (r_pos == 3'(r_nk - 4'd1)) ? 3'd0 : r_pos + 3'd1;
            if (r_pos == 3'd0)
                r_rcon <= xt(r_rcon);
            r_d <= '0;
        end
        if (do_dec) begin
            r_dec[r_d] <= (r_d == '0 || r_d == r_rounds) ? src_key
                                                         : inv_mix_columns(src_key);
            r_d <= r_d + 1'b1;
        end
    end

    assign o_busy     = r_start || (r_state != ST_IDLE);
    assign o_rounds   = r_rounds;
    assign o_enc_keys = r_enc;
    assign o_dec_keys = r_dec;

endmodule

`default_nettype wire

// ===== hw/rtl/aes_block_encrypt_decrypt.sv =====
// AES-128/192/256 block cipher, fully pipelined: one block per cycle unless stalled or busy.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata block, tuser op
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata result
//  cfg      | in        | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One registered stage adds round key 0, then one stage per round; stages past the last
// round of the key size just pass the block. One block per cycle unless stalled or busy.
// Reset is synchronous. After reset and after every register write the key schedule
// loads the key, expands it one word per cycle and then derives the decryption keys;
// s_axis_tready is low meanwhile. Config writes are always taken.
// A stall at the output backs up stage by stage; empty stages keep filling.
`default_nettype none

module aes_block_encrypt_decrypt
    import aes_pkg::*;
#(
    parameter int MAX_ROUND_KEYS = 15
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [127:0]      s_axis_tdata,   // block_hi, block_lo
    input  wire logic              s_axis_tuser,   // op
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [127:0]           m_axis_tdata,   // result_hi, result_lo
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [63:0]       i_cfg_data
);

    localparam int RW = $clog2(MAX_ROUND_KEYS);

    logic          busy;
    logic [RW-1:0] rounds;
    logic [127:0]  enc_keys [MAX_ROUND_KEYS];
    logic [127:0]  dec_keys [MAX_ROUND_KEYS];
    t_pipe_ctl     ctl [MAX_ROUND_KEYS+1];
    logic          rdy [MAX_ROUND_KEYS+1];
    logic [127:0]  st  [MAX_ROUND_KEYS+1];
    logic [1:0]    kind [MAX_ROUND_KEYS];

    aes_key_sched #(
        .MAX_ROUND_KEYS(MAX_ROUND_KEYS)
    ) u_key_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_rounds    (rounds),
        .o_enc_keys  (enc_keys),
        .o_dec_keys  (dec_keys)
    );

    assign o_cfg_ready = 1'b1;

    // Hold off new blocks while round keys are being rebuilt.
    assign ctl[0].valid  = s_axis_tvalid && !busy;
    assign ctl[0].op     = s_axis_tuser;
    assign st[0]         = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign s_axis_tready = rdy[0] && !busy;

    for (genvar g = 0; g < MAX_ROUND_KEYS; g++) begin : g_stage
        if (g == 0) begin : g_add
            assign kind[g] = RK_ADD;
        end else begin : g_rnd
            assign kind[g] = (RW'(g) < rounds)  ? RK_MID :
                             (RW'(g) == rounds) ? RK_FIN : RK_PASS;
        end
        aes_round u_round (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl[g]),
            .o_ready   (rdy[g]),
            .i_state   (st[g]),
            .i_key_enc (enc_keys[g]),
            .i_key_dec (dec_keys[g]),
            .i_kind    (kind[g]),
            .o_ctl     (ctl[g+1]),
            .i_ready   (rdy[g+1]),
            .o_state   (st[g+1])
        );
    end

    assign rdy[MAX_ROUND_KEYS] = m_axis_tready;
    assign m_axis_tvalid       = ctl[MAX_ROUND_KEYS].valid;
    assign m_axis_tdata        = {st[MAX_ROUND_KEYS][63:0], st[MAX_ROUND_KEYS][127:64]};

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !(s_axis_tvalid && s_axis_tready))
        else $error("block accepted during key expansion");

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index <= IDX_KEY_WORD3) |=> busy)
        else $error("register write did not restart key expansion");

    a_rounds_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (rounds == RW'(10) || rounds == RW'(12) || rounds == RW'(14) ||
                   rounds == RW'(MAX_ROUND_KEYS - 1)))
        else $error("round count out of range");

endmodule

`default_nettype wire
